@@ src/drst_pkg.sv @@
// ----------------------------------------------------------------------------
// drst_pkg
// shared types and constants of the datagram reassembly slot tracker
// ----------------------------------------------------------------------------
`default_nettype none

package drst_pkg;

  // table geometry and bounds
  localparam int SLOTS           = 10;
  localparam int MAX_SLICE_BYTES = 524288;
  localparam int MAX_PAYLOAD     = 2048;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int SEQ_W  = 31;
  localparam int SIZE_W = 20;
  // one bit above any legal size, so a saturated fill never equals a size
  localparam int FILL_W = SIZE_W + 1;
  localparam int LEN_W  = 12;

  localparam logic [23:0] MAGIC_TAG = 24'h4B514E;  // "KQN"
  localparam int OLD_MARGIN = 7;
  localparam int READ_LAG   = 5;
  localparam int CLAIM_LAG  = SLOTS - 2;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_TOO_OLD   = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_SIZE_MISM = 3'd3,
    ST_NO_SLOT   = 3'd4,
    ST_OUT_BOUND = 3'd5,
    ST_NONE_RDY  = 3'd6,
    ST_READY     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    MODE_MATCH = 2'd0,
    MODE_CLAIM = 2'd1,
    MODE_SIZE  = 2'd2,
    MODE_READ  = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [FILL_W-1:0] fill;
  } slot_entry_t;

  typedef struct packed {
    scan_mode_t        mode;
    logic [SEQ_W-1:0]  num;
    logic [SIZE_W-1:0] total;
    logic [31:0]       rd;
    logic [32:0]       claim_thr;
  } scan_req_t;

endpackage

`default_nettype wire

@@ src/drst_slot_table.sv @@
// ----------------------------------------------------------------------------
// drst_slot_table
// slot table with one indexed read/write port, cleared by reset
// ----------------------------------------------------------------------------
`default_nettype none

module drst_slot_table
  import drst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic              we,
  input  wire slot_entry_t       wdata,
  output slot_entry_t            rdata
);

  slot_entry_t entry_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        entry_r[i] <= '0;
      end
    end else if (we) begin
      entry_r[idx] <= wdata;
    end
  end

  assign rdata = entry_r[idx];

endmodule

`default_nettype wire

@@ src/drst_scan_unit.sv @@
// ----------------------------------------------------------------------------
// drst_scan_unit
// shared compare unit, evaluates one slot per cycle for the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module drst_scan_unit
  import drst_pkg::*;
(
  input  wire scan_req_t   req,
  input  wire slot_entry_t entry,
  output logic             hit
);

  logic seq_lt_thr;
  logic fill_eq_size;

  assign seq_lt_thr   = $signed({2'b00, entry.seq}) < $signed(req.claim_thr);
  assign fill_eq_size = entry.fill == {1'b0, entry.size};

  always_comb begin
    case (req.mode)
      MODE_MATCH: hit = entry.seq == req.num;
      MODE_CLAIM: hit = (entry.seq == '0) || seq_lt_thr;
      MODE_SIZE:  hit = entry.size == req.total;
      MODE_READ:  hit = ({1'b0, entry.seq} == req.rd) && fill_eq_size;
      default:    hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/datagram_reassembly_slot_tracker.sv @@
// ----------------------------------------------------------------------------
// datagram_reassembly_slot_tracker
// reassembly bookkeeping for sliced messages over a table of slots
// ----------------------------------------------------------------------------
// Each input beat is either a fragment header (op 0) or a read request
// (op 1) and gives exactly one result beat. A small sequencer walks the slot
// table one entry per cycle through a single shared compare unit: a write
// does a header check and, if it passes, a match scan over up to SLOTS
// entries, a claim scan over up to SLOTS entries when no slot matches (or
// the slice number is zero), an update when a slot is found, and a hand-off;
// a read does a catch-up step, a scan over up to SLOTS entries and the
// hand-off. in_ready is high only while the sequencer is idle, so a new beat
// is not taken until the last one has been handed off. A finished result
// sits in the output register, so the next beat is taken while it waits for
// out_ready; the hand-off of a further result waits until that register is
// free.
// The table is cleared by reset, no clearing pass follows. Payload bytes
// are not stored here; write_offset tells where they belong in the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_reassembly_slot_tracker
  import drst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  input  wire logic [23:0]       in_magic,
  input  wire logic [30:0]       in_slice_number,
  input  wire logic [19:0]       in_payload_offset,
  input  wire logic [19:0]       in_slice_total,
  input  wire logic [11:0]       in_payload_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic [3:0]             out_slot,
  output logic [19:0]            out_write_offset,
  output logic [19:0]            out_byte_count,
  output logic                   out_readjusted
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MATCH,
    S_CLAIM,
    S_UPDATE,
    S_RD_ADJ,
    S_READ,
    S_DONE
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // latched header of the beat in work
  logic [23:0]       magic_r, magic_nxt;
  logic [SEQ_W-1:0]  num_r, num_nxt;
  logic [19:0]       off_r, off_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  // tracker state
  logic [SEQ_W-1:0] newest_r, newest_nxt;
  logic [31:0]      rd_seq_r, rd_seq_nxt;

  // result waiting for the output register
  status_t           res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic [19:0]       res_off_r, res_off_nxt;
  logic [19:0]       res_cnt_r, res_cnt_nxt;
  logic              res_adj_r, res_adj_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [19:0] out_off_r, out_off_nxt;
  logic [19:0] out_cnt_r, out_cnt_nxt;
  logic        out_adj_r, out_adj_nxt;

  // table port and shared unit
  logic        tbl_we;
  slot_entry_t tbl_wdata;
  slot_entry_t tbl_rdata;
  scan_req_t   scan_req;
  logic        scan_hit;

  // thresholds relative to the newest slice, signed 33 bits
  logic [32:0] newest_s;
  logic [32:0] old_thr;
  logic [32:0] claim_thr;
  logic [32:0] lag_thr;
  logic        too_old;
  logic        out_of_bounds;
  logic [20:0] end_byte;
  logic [21:0] fill_sum;
  logic [FILL_W-1:0] fill_sat;

  assign newest_s  = {2'b00, newest_r};
  assign old_thr   = newest_s - 33'(OLD_MARGIN);
  assign claim_thr = newest_s - 33'(CLAIM_LAG);
  assign lag_thr   = newest_s - 33'(READ_LAG);

  assign too_old  = $signed({2'b00, num_r}) < $signed(old_thr);
  assign end_byte = {1'b0, off_r} + 21'(len_r);
  assign out_of_bounds = (32'(len_r) > 32'(MAX_PAYLOAD))
                      || (32'(total_r) > 32'(MAX_SLICE_BYTES))
                      || (32'(end_byte) > 32'(MAX_SLICE_BYTES));

  // fill saturates at all ones, above any legal size
  assign fill_sum = {1'b0, tbl_rdata.fill} + 22'(len_r);
  assign fill_sat = fill_sum[21] ? '1 : fill_sum[FILL_W-1:0];

  drst_slot_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .idx   (idx_r),
    .we    (tbl_we),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  drst_scan_unit u_scan (
    .req   (scan_req),
    .entry (tbl_rdata),
    .hit   (scan_hit)
  );

  always_comb begin
    scan_req.num       = num_r;
    scan_req.total     = total_r;
    scan_req.rd        = rd_seq_r;
    scan_req.claim_thr = claim_thr;
    case (state_r)
      S_CLAIM:  scan_req.mode = MODE_CLAIM;
      S_UPDATE: scan_req.mode = MODE_SIZE;
      S_READ:   scan_req.mode = MODE_READ;
      default:  scan_req.mode = MODE_MATCH;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    magic_nxt      = magic_r;
    num_nxt        = num_r;
    off_nxt        = off_r;
    total_nxt      = total_r;
    len_nxt        = len_r;
    newest_nxt     = newest_r;
    rd_seq_nxt     = rd_seq_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_off_nxt    = res_off_r;
    res_cnt_nxt    = res_cnt_r;
    res_adj_nxt    = res_adj_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_off_nxt    = out_off_r;
    out_cnt_nxt    = out_cnt_r;
    out_adj_nxt    = out_adj_r;
    tbl_we         = 1'b0;
    tbl_wdata      = tbl_rdata;

    // output beat leaves on handshake
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          magic_nxt = in_magic;
          num_nxt   = in_slice_number;
          off_nxt   = in_payload_offset;
          total_nxt = in_slice_total;
          len_nxt   = in_payload_length;
          idx_nxt   = '0;
          state_nxt = in_op ? S_RD_ADJ : S_CHECK;
        end
      end

      S_CHECK: begin
        res_slot_nxt = '0;
        res_off_nxt  = '0;
        res_cnt_nxt  = '0;
        res_adj_nxt  = 1'b0;
        if (magic_r != MAGIC_TAG) begin
          res_status_nxt = ST_BAD_MAGIC;
          state_nxt      = S_DONE;
        end else if (too_old) begin
          res_status_nxt = ST_TOO_OLD;
          state_nxt      = S_DONE;
        end else if (out_of_bounds) begin
          res_status_nxt = ST_OUT_BOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = '0;
          // slice number zero always goes to the claim scan for a fresh slot
          state_nxt = (num_r == '0) ? S_CLAIM : S_MATCH;
        end
      end

      S_MATCH: begin
        if (scan_hit) begin
          state_nxt = S_UPDATE;
        end else if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_CLAIM;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_CLAIM: begin
        if (scan_hit) begin
          tbl_we         = 1'b1;
          tbl_wdata.seq  = num_r;
          tbl_wdata.size = total_r;
          tbl_wdata.fill = '0;
          state_nxt      = S_UPDATE;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_NO_SLOT;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_UPDATE: begin
        res_slot_nxt = idx_r;
        state_nxt    = S_DONE;
        if (!scan_hit) begin
          res_status_nxt = ST_SIZE_MISM;
        end else begin
          tbl_we         = 1'b1;
          tbl_wdata.fill = fill_sat;
          if (num_r > newest_r) begin
            newest_nxt = num_r;
          end
          res_status_nxt = ST_WRITTEN;
          res_off_nxt    = off_r;
          res_cnt_nxt    = 20'(len_r);
        end
      end

      S_RD_ADJ: begin
        // pull the read position forward when it lags too far
        res_adj_nxt = 1'b0;
        if ($signed({rd_seq_r[31], rd_seq_r}) < $signed(lag_thr)) begin
          rd_seq_nxt  = lag_thr[31:0];
          res_adj_nxt = 1'b1;
        end
        idx_nxt   = '0;
        state_nxt = S_READ;
      end

      S_READ: begin
        if (scan_hit) begin
          rd_seq_nxt     = rd_seq_r + 32'd1;
          res_status_nxt = ST_READY;
          res_slot_nxt   = idx_r;
          res_off_nxt    = '0;
          res_cnt_nxt    = tbl_rdata.size;
          state_nxt      = S_DONE;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_NONE_RDY;
          res_slot_nxt   = '0;
          res_off_nxt    = '0;
          res_cnt_nxt    = '0;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = 4'(res_slot_r);
          out_off_nxt    = res_off_r;
          out_cnt_nxt    = res_cnt_r;
          out_adj_nxt    = res_adj_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      newest_r    <= '0;
      rd_seq_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      newest_r    <= newest_nxt;
      rd_seq_r    <= rd_seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    magic_r      <= magic_nxt;
    num_r        <= num_nxt;
    off_r        <= off_nxt;
    total_r      <= total_nxt;
    len_r        <= len_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_off_r    <= res_off_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_adj_r    <= res_adj_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_off_r    <= out_off_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_adj_r    <= out_adj_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_write_offset = out_off_r;
  assign out_byte_count   = out_cnt_r;
  assign out_readjusted   = out_adj_r;

endmodule

`default_nettype wire
